/* rtl/sie_pkg.sv */
`default_nettype none

package sie_pkg;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned REG_AW   = 4;
    localparam int unsigned MEM_AW   = 8;
    localparam int unsigned IP_W     = 16;
    localparam int unsigned IMM_W    = 32;
    localparam int unsigned OPCODE_W = 5;
    localparam int unsigned FLAGS_W  = 4;

    // compare flag bit positions
    localparam int unsigned FLAG_EQ = 0;
    localparam int unsigned FLAG_NE = 1;
    localparam int unsigned FLAG_LT = 2;
    localparam int unsigned FLAG_GT = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LDR  = 5'd0,
        OP_STR  = 5'd1,
        OP_ADD  = 5'd2,
        OP_SUB  = 5'd3,
        OP_MOV  = 5'd4,
        OP_CMP  = 5'd5,
        OP_B    = 5'd6,
        OP_BEQ  = 5'd7,
        OP_BNE  = 5'd8,
        OP_BGT  = 5'd9,
        OP_BLT  = 5'd10,
        OP_AND  = 5'd11,
        OP_ORR  = 5'd12,
        OP_EOR  = 5'd13,
        OP_MVN  = 5'd14,
        OP_LSL  = 5'd15,
        OP_LSR  = 5'd16,
        OP_HALT = 5'd17,
        OP_OUT  = 5'd18
    } t_op;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_rf_wr;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        t_rf_wr             rf_wr;
        t_mem_wr            mem_wr;
        logic               flags_we;
        logic [FLAGS_W-1:0] flags;
        logic [IP_W-1:0]    next_ip;
        logic               branch_taken;
        logic               halted;
        logic               out_valid;
        logic [REG_AW-1:0]  out_reg;
        logic [DATA_W-1:0]  out_value;
    } t_commit;

endpackage

`default_nettype wire

/* rtl/sie_regfile.sv */
`default_nettype none

module sie_regfile
    import sie_pkg::*;
#(
    parameter int unsigned NUM_REGS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [REG_AW-1:0] i_rd_addr_a,
    input  wire logic [REG_AW-1:0] i_rd_addr_b,
    input  wire t_rf_wr            i_wr,
    output logic      [DATA_W-1:0] o_rdata_a,
    output logic      [DATA_W-1:0] o_rdata_b
);

    localparam int unsigned RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [DATA_W-1:0] r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    logic          wr_ok, ok_a, ok_b, hit_a, hit_b;
    logic [RW-1:0] widx, idx_a, idx_b;

    assign wr_ok = ({1'b0, i_wr.addr} < (REG_AW+1)'(NUM_REGS));
    assign ok_a  = ({1'b0, i_rd_addr_a} < (REG_AW+1)'(NUM_REGS));
    assign ok_b  = ({1'b0, i_rd_addr_b} < (REG_AW+1)'(NUM_REGS));
    assign widx  = i_wr.addr[RW-1:0];
    assign idx_a = i_rd_addr_a[RW-1:0];
    assign idx_b = i_rd_addr_b[RW-1:0];
    // write at the same edge as the read: pass the new value through
    assign hit_a = i_wr.en && wr_ok && (i_wr.addr == i_rd_addr_a);
    assign hit_b = i_wr.en && wr_ok && (i_wr.addr == i_rd_addr_b);

    // entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en && wr_ok) begin
            r_vld[widx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && wr_ok) begin
            r_mem[widx] <= i_wr.data;
        end
        if (i_rd_en) begin
            if (!ok_a) begin
                r_rdata_a <= '0;
            end else if (hit_a) begin
                r_rdata_a <= i_wr.data;
            end else if (!r_vld[idx_a]) begin
                r_rdata_a <= '0;
            end else begin
                r_rdata_a <= r_mem[idx_a];
            end
            if (!ok_b) begin
                r_rdata_b <= '0;
            end else if (hit_b) begin
                r_rdata_b <= i_wr.data;
            end else if (!r_vld[idx_b]) begin
                r_rdata_b <= '0;
            end else begin
                r_rdata_b <= r_mem[idx_b];
            end
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

/* rtl/sie_datamem.sv */
`default_nettype none

module sie_datamem
    import sie_pkg::*;
#(
    parameter int unsigned MEM_WORDS = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [MEM_AW-1:0] i_rd_addr,
    input  wire t_mem_wr           i_wr,
    output logic      [DATA_W-1:0] o_rdata,
    output logic                   o_busy
);

    localparam int unsigned AW = $clog2(MEM_WORDS);
    localparam int unsigned XW = (AW > MEM_AW) ? AW : MEM_AW;

    logic [DATA_W-1:0] r_mem [MEM_WORDS];
    logic [DATA_W-1:0] r_raw;
    logic [DATA_W-1:0] r_fwd_data;
    logic              r_fwd;
    logic              r_zero;
    logic              r_busy;
    logic [AW-1:0]     r_clr_cnt;

    logic          rd_ok, wr_ok, fwd_hit;
    logic [XW-1:0] rd_x, wr_x;
    logic [AW-1:0] ridx, widx;

    assign rd_ok   = (32'(i_rd_addr) < 32'(MEM_WORDS));
    assign wr_ok   = (32'(i_wr.addr) < 32'(MEM_WORDS));
    assign rd_x    = XW'(i_rd_addr);
    assign wr_x    = XW'(i_wr.addr);
    assign ridx    = rd_x[AW-1:0];
    assign widx    = wr_x[AW-1:0];
    assign fwd_hit = i_wr.en && wr_ok && (i_wr.addr == i_rd_addr);

    // clearing sweep after reset, one word a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_cnt <= '0;
        end else if (r_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == AW'(MEM_WORDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_cnt] <= '0;
        end else if (i_wr.en && wr_ok) begin
            r_mem[widx] <= i_wr.data;
        end
    end

    // read-first array; a store at the read edge goes through the bypass
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_raw      <= r_mem[ridx];
            r_zero     <= !rd_ok;
            r_fwd      <= fwd_hit;
            r_fwd_data <= i_wr.data;
        end
    end

    assign o_rdata = r_zero ? '0 : (r_fwd ? r_fwd_data : r_raw);
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

/* rtl/sie_exec.sv */
`default_nettype none

module sie_exec
    import sie_pkg::*;
(
    input  wire logic [OPCODE_W-1:0] i_op,
    input  wire logic [REG_AW-1:0]   i_dest,
    input  wire logic                i_imm_sel,
    input  wire logic [IMM_W-1:0]    i_imm,
    input  wire logic [MEM_AW-1:0]   i_mem_addr,
    input  wire logic [IP_W-1:0]     i_target,
    input  wire logic [DATA_W-1:0]   i_opa,
    input  wire logic [DATA_W-1:0]   i_opb,
    input  wire logic [DATA_W-1:0]   i_load,
    input  wire logic [FLAGS_W-1:0]  i_flags,
    input  wire logic [IP_W-1:0]     i_ip,
    output t_commit                  o_commit
);

    logic [DATA_W-1:0] opnd2;
    logic              sh_big;
    logic              eq, lt;
    logic              taken;

    assign opnd2  = i_imm_sel ? DATA_W'(i_imm) : i_opb;
    assign sh_big = |opnd2[DATA_W-1:6];
    assign eq     = (i_opa == opnd2);
    assign lt     = (i_opa < opnd2);

    always_comb begin
        o_commit             = '0;
        o_commit.rf_wr.addr  = i_dest;
        o_commit.mem_wr.addr = i_mem_addr;
        o_commit.mem_wr.data = i_opa;
        o_commit.next_ip     = i_ip + 1'b1;
        o_commit.flags       = i_flags;
        taken                = 1'b0;

        unique case (i_op)
            OP_LDR: begin
                o_commit.rf_wr.en   = 1'b1;
                o_commit.rf_wr.data = i_load;
            end
            OP_STR: o_commit.mem_wr.en = 1'b1;
            OP_ADD: begin
                o_commit.rf_wr.en   = 1'b1;
                o_commit.rf_wr.data = i_opa + opnd2;
            end
            OP_SUB: begin
                o_commit.rf_wr.en   = 1'b1;
                o_commit.rf_wr.data = i_opa - opnd2;
            end
            OP_MOV: begin
                o_commit.rf_wr.en   = 1'b1;
                o_commit.rf_wr.data = opnd2;
            end
            OP_CMP: begin
                o_commit.flags_we        = 1'b1;
                o_commit.flags[FLAG_EQ]  = eq;
                o_commit.flags[FLAG_NE]  = !eq;
                o_commit.flags[FLAG_LT]  = lt;
                o_commit.flags[FLAG_GT]  = !eq && !lt;
            end
            OP_B:   taken = 1'b1;
            OP_BEQ: taken = i_flags[FLAG_EQ];
            OP_BNE: taken = i_flags[FLAG_NE];
            OP_BGT: taken = i_flags[FLAG_GT];
            OP_BLT: taken = i_flags[FLAG_LT];
            OP_AND: begin
                o_commit.rf_wr.en   = 1'b1;
                o_commit.rf_wr.data = i_opa & opnd2;
            end
            OP_ORR: begin
                o_commit.rf_wr.en   = 1'b1;
                o_commit.rf_wr.data = i_opa | opnd2;
            end
            OP_EOR: begin
                o_commit.rf_wr.en   = 1'b1;
                o_commit.rf_wr.data = i_opa ^ opnd2;
            end
            OP_MVN: begin
                o_commit.rf_wr.en   = 1'b1;
                o_commit.rf_wr.data = ~opnd2;
            end
            OP_LSL: begin
                o_commit.rf_wr.en   = 1'b1;
                o_commit.rf_wr.data = sh_big ? '0 : (i_opa << opnd2[5:0]);
            end
            OP_LSR: begin
                o_commit.rf_wr.en   = 1'b1;
                o_commit.rf_wr.data = sh_big ? '0 : (i_opa >> opnd2[5:0]);
            end
            OP_HALT: begin
                // pointer holds; operand A carries R0
                o_commit.halted    = 1'b1;
                o_commit.out_valid = 1'b1;
                o_commit.out_value = i_opa;
                o_commit.next_ip   = i_ip;
            end
            OP_OUT: begin
                o_commit.out_valid = 1'b1;
                o_commit.out_reg   = i_dest;
                o_commit.out_value = i_opa;
            end
            default: ;
        endcase

        if (taken) begin
            o_commit.branch_taken = 1'b1;
            o_commit.next_ip      = i_target;
            o_commit.flags_we     = 1'b1;
            o_commit.flags        = '1;
        end
    end

endmodule

`default_nettype wire

/* rtl/small_isa_execute_unit.sv */
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------------
// request   | in        | i_req_valid / o_req_ready  | type, regs, operand2, addr, target
// response  | out       | o_rsp_valid / i_rsp_ready  | next_ip, taken, halted, out value
//
// One instruction per cycle sustained while the response is taken; the beat is
// registered in the input stage and the result in the response register. The input
// stage reads the register file (two ports) and the data memory; execute writes the
// response register and the state. After reset the data memory is swept to zero with
// ready low. A stalled response holds the executing beat; ready follows the result register.

module small_isa_execute_unit
    import sie_pkg::*;
#(
    parameter int unsigned NUM_REGS  = 16,
    parameter int unsigned MEM_WORDS = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                i_req_valid,
    output logic                     o_req_ready,
    input  wire logic [OPCODE_W-1:0] i_req_type,
    input  wire logic [REG_AW-1:0]   i_dest_reg,
    input  wire logic [REG_AW-1:0]   i_src_reg,
    input  wire logic                i_op2_is_imm,
    input  wire logic [REG_AW-1:0]   i_op2_reg,
    input  wire logic [IMM_W-1:0]    i_imm_value,
    input  wire logic [MEM_AW-1:0]   i_mem_addr,
    input  wire logic [IP_W-1:0]     i_branch_target,

    output logic                     o_rsp_valid,
    input  wire logic                i_rsp_ready,
    output logic [IP_W-1:0]          o_next_ip,
    output logic                     o_branch_taken,
    output logic                     o_halted,
    output logic                     o_out_valid,
    output logic [REG_AW-1:0]        o_out_reg,
    output logic [DATA_W-1:0]        o_out_value
);

    // input stage
    logic                r_in_vld;
    logic [OPCODE_W-1:0] r_type;
    logic [REG_AW-1:0]   r_dest;
    logic                r_imm_sel;
    logic [IMM_W-1:0]    r_imm;
    logic [MEM_AW-1:0]   r_maddr;
    logic [IP_W-1:0]     r_target;

    // architectural state
    logic [FLAGS_W-1:0]  r_flags;
    logic [IP_W-1:0]     r_ip;

    // response register
    logic                r_out_vld;
    logic [IP_W-1:0]     r_next_ip;
    logic                r_taken;
    logic                r_halted;
    logic                r_ovalid;
    logic [REG_AW-1:0]   r_oreg;
    logic [DATA_W-1:0]   r_oval;

    logic                accept;
    logic                exec_fire;
    logic                mem_busy;
    logic [REG_AW-1:0]   rd_addr_a;
    logic [DATA_W-1:0]   opa, opb, load_data;
    t_commit             commit;
    t_rf_wr              rf_wr;
    t_mem_wr             mem_wr;

    assign exec_fire   = r_in_vld && (!r_out_vld || i_rsp_ready);
    assign o_req_ready = !mem_busy && (!r_in_vld || exec_fire);
    assign accept      = i_req_valid && o_req_ready;

    // port A: Rd for compare/store/output, R0 for halt, Rn otherwise
    always_comb begin
        priority if (i_req_type == OP_STR || i_req_type == OP_CMP ||
                     i_req_type == OP_OUT) begin
            rd_addr_a = i_dest_reg;
        end else if (i_req_type == OP_HALT) begin
            rd_addr_a = '0;
        end else begin
            rd_addr_a = i_src_reg;
        end
    end

    always_comb begin
        rf_wr     = commit.rf_wr;
        rf_wr.en  = commit.rf_wr.en && exec_fire;
        mem_wr    = commit.mem_wr;
        mem_wr.en = commit.mem_wr.en && exec_fire;
    end

    sie_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (i_op2_reg),
        .i_wr        (rf_wr),
        .o_rdata_a   (opa),
        .o_rdata_b   (opb)
    );

    sie_datamem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datamem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (i_mem_addr),
        .i_wr      (mem_wr),
        .o_rdata   (load_data),
        .o_busy    (mem_busy)
    );

    sie_exec u_exec (
        .i_op       (r_type),
        .i_dest     (r_dest),
        .i_imm_sel  (r_imm_sel),
        .i_imm      (r_imm),
        .i_mem_addr (r_maddr),
        .i_target   (r_target),
        .i_opa      (opa),
        .i_opb      (opb),
        .i_load     (load_data),
        .i_flags    (r_flags),
        .i_ip       (r_ip),
        .o_commit   (commit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (exec_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type    <= i_req_type;
            r_dest    <= i_dest_reg;
            r_imm_sel <= i_op2_is_imm;
            r_imm     <= i_imm_value;
            r_maddr   <= i_mem_addr;
            r_target  <= i_branch_target;
        end
    end

    // flags and pointer move only when an instruction retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_ip    <= '0;
        end else if (exec_fire) begin
            r_ip <= commit.next_ip;
            if (commit.flags_we) begin
                r_flags <= commit.flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (exec_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_next_ip <= commit.next_ip;
            r_taken   <= commit.branch_taken;
            r_halted  <= commit.halted;
            r_ovalid  <= commit.out_valid;
            r_oreg    <= commit.out_reg;
            r_oval    <= commit.out_value;
        end
    end

    assign o_rsp_valid    = r_out_vld;
    assign o_next_ip      = r_next_ip;
    assign o_branch_taken = r_taken;
    assign o_halted       = r_halted;
    assign o_out_valid    = r_ovalid;
    assign o_out_reg      = r_oreg;
    assign o_out_value    = r_oval;

endmodule

`default_nettype wire
